[hdl/cdq_pkg.sv]
`default_nettype none

package cdq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int WORD_W        = 32;

    typedef enum logic [1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_REAR  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_REAR   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        func_t                     func;
        logic signed [WORD_W-1:0]  push_value;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic signed [WORD_W-1:0]  popped_value;
    } rsp_t;

    // Controller to datapath: one word's worth of work.
    typedef struct packed {
        logic    load;
        logic    push_front;
        logic    push_rear;
        logic    pop_front;
        logic    pop_rear;
        status_t status;
    } dp_cmd_t;

    // Datapath to controller: occupancy flags.
    typedef struct packed {
        logic full;
        logic empty;
    } dp_sts_t;

endpackage

`default_nettype wire

[hdl/cdq_datapath.sv]
`default_nettype none

module cdq_datapath #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cdq_pkg::dp_cmd_t       cmd,
    input  wire logic signed [31:0]     push_value,
    output cdq_pkg::dp_sts_t            sts,
    output cdq_pkg::rsp_t               rsp
);
    import cdq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [WORD_W-1:0] slot_mem [DEPTH];

    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] rear_reg, rear_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic signed [WORD_W-1:0] rdata_reg;
    status_t          status_reg;
    logic             pop_ok_reg;

    logic [IDX_W-1:0] front_dec, front_inc, rear_dec, rear_inc;
    logic [IDX_W-1:0] waddr, raddr;
    logic             do_push, do_pop;

    always_comb
    begin
        front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
        front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
        rear_dec  = (rear_reg == '0) ? IDX_W'(DEPTH - 1) : rear_reg - 1'b1;
        rear_inc  = (rear_reg == IDX_W'(DEPTH - 1)) ? '0 : rear_reg + 1'b1;

        do_push = cmd.push_front | cmd.push_rear;
        do_pop  = cmd.pop_front | cmd.pop_rear;

        waddr = cmd.push_front ? front_dec : rear_reg;
        raddr = cmd.pop_front ? front_reg : rear_dec;

        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        if (cmd.push_front)
        begin
            front_next = front_dec;
        end
        if (cmd.pop_front)
        begin
            front_next = front_inc;
        end
        if (cmd.push_rear)
        begin
            rear_next = rear_inc;
        end
        if (cmd.pop_rear)
        begin
            rear_next = rear_dec;
        end
        if (do_push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            rear_reg   <= '0;
            count_reg  <= '0;
            status_reg <= STATUS_OK;
            pop_ok_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
            if (cmd.load)
            begin
                status_reg <= cmd.status;
                pop_ok_reg <= do_pop;
            end
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_mem[waddr] <= push_value;
        end
        if (do_pop)
        begin
            rdata_reg <= slot_mem[raddr];
        end
    end

    assign sts.full         = (count_reg == CNT_W'(DEPTH));
    assign sts.empty        = (count_reg == '0);
    assign rsp.status       = status_reg;
    assign rsp.popped_value = pop_ok_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

[hdl/cdq_ctrl.sv]
`default_nettype none

module cdq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire cdq_pkg::func_t     func,
    output logic                    req_stall,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    input  wire cdq_pkg::dp_sts_t   sts,
    output cdq_pkg::dp_cmd_t        cmd
);
    import cdq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   ready;

    // Take a word when nothing is held, or when the held result leaves now.
    assign ready     = (state_reg == ST_IDLE) || !rsp_stall;
    assign req_stall = !ready;
    assign rsp_valid = (state_reg == ST_BUSY);

    always_comb
    begin
        cmd        = '0;
        cmd.status = STATUS_OK;
        if (ready && req_valid)
        begin
            cmd.load = 1'b1;
            unique case (func)
                FUNC_PUSH_FRONT:
                begin
                    if (sts.full) cmd.status = STATUS_FULL;
                    else          cmd.push_front = 1'b1;
                end
                FUNC_PUSH_REAR:
                begin
                    if (sts.full) cmd.status = STATUS_FULL;
                    else          cmd.push_rear = 1'b1;
                end
                FUNC_POP_FRONT:
                begin
                    if (sts.empty) cmd.status = STATUS_EMPTY;
                    else           cmd.pop_front = 1'b1;
                end
                FUNC_POP_REAR:
                begin
                    if (sts.empty) cmd.status = STATUS_EMPTY;
                    else           cmd.pop_rear = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (!rsp_stall && !req_valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hdl/circular_deque.sv]
// Circular double-ended queue of signed 32-bit words, DEPTH deep. Each request word
// carries one operation (push front, push rear, pop front, pop rear) and yields
// exactly one response word with a status (ok, full, empty) and, for a good pop,
// the removed value (zero otherwise). Refused operations change nothing. A request
// is answered in the cycle after it is taken, from an output register; the block takes
// a new request in the same cycle the held response is taken, so it sustains one
// request per cycle when the response side does not stall, and any stall simply
// holds the response and the request side together. The popped value comes from
// the registered read port of the slot memory. Slots come out of reset
// undefined; only live slots are ever read.
`default_nettype none

module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire cdq_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output cdq_pkg::rsp_t       rsp
);
    import cdq_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Controller: decide accept and whether the operation goes ahead.
    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .func      (req.func),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: pointers, occupancy, slot memory and response register.
    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_value (req.push_value),
        .sts        (sts),
        .rsp        (rsp)
    );

`ifndef NO_ASSERTIONS
    // A taken request always shows its response in the next cycle.
    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> rsp_valid)
        else $error("response missing after accepted request");

    // A new request never overwrites a response still held.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && rsp_valid) |-> !rsp_stall)
        else $error("held response overwritten");

    // Refused operations report a zero value.
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != STATUS_OK) |-> (rsp.popped_value == '0))
        else $error("refused operation returned data");

    // Full and empty never hold together.
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(sts.full && sts.empty))
        else $error("deque both full and empty");
`endif

endmodule

`default_nettype wire

[dv/tb_circular_deque.sv]
module tb_circular_deque;
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    // Deque depth, index width and run limits
    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int IW          = $clog2(DEPTH);
    localparam int DIR_N       = 25;
    localparam int PHASE_ITEMS = 285;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 200000;

    // Per-phase idling, in percent of cycles: no idling, sender idle,
    // receiver stalling, then both lightly
    localparam int SENDER_IDLE [4] = '{0, 59, 0, 10};
    localparam int RECV_STALL  [4] = '{0, 0, 59, 10};

    // One directed row: the request word, plus a typed-in answer where the
    // answer is obvious (error codes, extremes, just-pushed words)
    typedef struct packed {
        func_t                    op;
        logic signed [WORD_W-1:0] word;
        logic                     typed;
        status_t                  st;
        logic signed [WORD_W-1:0] pop;
    } dir_row_t;

    // What the monitor should use for the next accepted request
    typedef struct {
        bit   typed;
        rsp_t rsp;
    } hint_t;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req       = '0;
    logic  rsp_valid;
    logic  rsp_stall = 1'b0;
    rsp_t  rsp;

    // Receiver knobs, written by the stimulus process with nonblocking
    // assignments so the receiver always sees a settled value
    int    stall_pct = 0;
    int    hold_req  = 0;
    int    hold_seen = 0;
    int    hold_left = 0;

    // Predicted deque contents
    logic signed [WORD_W-1:0] ring [DEPTH];
    logic [IW-1:0]            head = '0;
    logic [IW-1:0]            tail = '0;
    logic [IW:0]              fill = '0;

    hint_t hint_q [$];
    rsp_t  due_q  [$];

    int    err_cnt    = 0;
    int    cycle_cnt  = 0;
    int    n_checked  = 0;
    int    n_full     = 0;
    int    n_empty    = 0;
    int    n_good_pop = 0;

    // Directed sweep: pops on an empty deque, both extremes pushed and
    // popped at either end, a fill to capacity with the front index wrapping
    // below zero, both pushes refused when full, a full drain from
    // alternating ends, and one more pop refused when empty.
    dir_row_t dir_tab [DIR_N] = '{
        '{FUNC_POP_FRONT,  32'shDEAD_BEEF, 1'b1, STATUS_EMPTY, 32'sh0},
        '{FUNC_POP_REAR,   32'sh1234_5678, 1'b1, STATUS_EMPTY, 32'sh0},
        '{FUNC_PUSH_REAR,  32'sh7FFF_FFFF, 1'b1, STATUS_OK,    32'sh0},
        '{FUNC_POP_FRONT,  32'sh0,         1'b1, STATUS_OK,    32'sh7FFF_FFFF},
        '{FUNC_PUSH_FRONT, 32'sh8000_0000, 1'b1, STATUS_OK,    32'sh0},
        '{FUNC_POP_REAR,   32'shFFFF_FFFF, 1'b1, STATUS_OK,    32'sh8000_0000},
        '{FUNC_PUSH_FRONT, 32'shFFFF_FFFF, 1'b1, STATUS_OK,    32'sh0},
        '{FUNC_PUSH_REAR,  32'sh0,         1'b1, STATUS_OK,    32'sh0},
        '{FUNC_PUSH_FRONT, 32'sh0000_0001, 1'b1, STATUS_OK,    32'sh0},
        '{FUNC_PUSH_REAR,  32'sh5555_5555, 1'b1, STATUS_OK,    32'sh0},
        '{FUNC_PUSH_FRONT, 32'shAAAA_AAAA, 1'b1, STATUS_OK,    32'sh0},
        '{FUNC_PUSH_REAR,  32'sh8000_0000, 1'b1, STATUS_OK,    32'sh0},
        '{FUNC_PUSH_FRONT, 32'sh7FFF_FFFF, 1'b1, STATUS_OK,    32'sh0},
        '{FUNC_PUSH_REAR,  32'sh0F0F_0F0F, 1'b1, STATUS_OK,    32'sh0},
        '{FUNC_PUSH_FRONT, 32'sh1357_9BDF, 1'b1, STATUS_FULL,  32'sh0},
        '{FUNC_PUSH_REAR,  32'sh2468_ACE0, 1'b1, STATUS_FULL,  32'sh0},
        '{FUNC_POP_REAR,   32'shFFFF_FFFF, 1'b0, STATUS_OK,    32'sh0},
        '{FUNC_POP_FRONT,  32'sh0,         1'b0, STATUS_OK,    32'sh0},
        '{FUNC_POP_REAR,   32'sh8000_0000, 1'b0, STATUS_OK,    32'sh0},
        '{FUNC_POP_FRONT,  32'sh7FFF_FFFF, 1'b0, STATUS_OK,    32'sh0},
        '{FUNC_POP_REAR,   32'sh0,         1'b0, STATUS_OK,    32'sh0},
        '{FUNC_POP_FRONT,  32'sh0,         1'b0, STATUS_OK,    32'sh0},
        '{FUNC_POP_REAR,   32'sh0,         1'b0, STATUS_OK,    32'sh0},
        '{FUNC_POP_FRONT,  32'sh0,         1'b0, STATUS_OK,    32'sh0},
        '{FUNC_POP_FRONT,  32'shCAFE_F00D, 1'b1, STATUS_EMPTY, 32'sh0}
    };

    circular_deque #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Index arithmetic, wrapping modulo the depth
    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
        return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
        return (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
    endfunction

    // Apply one request to the predicted deque and return its answer.
    // A refused push or pop leaves head, tail and fill untouched.
    function automatic rsp_t deque_step(input req_t r);
        rsp_t o;
        o.status       = STATUS_OK;
        o.popped_value = '0;
        case (r.func)
            FUNC_PUSH_FRONT:
                if (fill == (IW+1)'(DEPTH))
                begin
                    o.status = STATUS_FULL;
                end
                else
                begin
                    head       = ring_prev(head);
                    ring[head] = r.push_value;
                    fill       = fill + 1'b1;
                end
            FUNC_PUSH_REAR:
                if (fill == (IW+1)'(DEPTH))
                begin
                    o.status = STATUS_FULL;
                end
                else
                begin
                    ring[tail] = r.push_value;
                    tail       = ring_next(tail);
                    fill       = fill + 1'b1;
                end
            FUNC_POP_FRONT:
                if (fill == '0)
                begin
                    o.status = STATUS_EMPTY;
                end
                else
                begin
                    o.popped_value = ring[head];
                    head           = ring_next(head);
                    fill           = fill - 1'b1;
                end
            default:
                if (fill == '0)
                begin
                    o.status = STATUS_EMPTY;
                end
                else
                begin
                    tail           = ring_prev(tail);
                    o.popped_value = ring[tail];
                    fill           = fill - 1'b1;
                end
        endcase
        return o;
    endfunction

    // Print one line per mismatch and count every one
    task automatic report_mismatch(input string what);
        err_cnt++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Biased operation pick: push_pct steers the deque toward full or empty
    function automatic func_t pick_op(input int push_pct);
        bit front;
        front = 1'($urandom_range(1));
        if ($urandom_range(99) < push_pct)
            return front ? FUNC_PUSH_FRONT : FUNC_PUSH_REAR;
        return front ? FUNC_POP_FRONT : FUNC_POP_REAR;
    endfunction

    // Half full-range random words, half the extremes, minus one and zero
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'shFFFF_FFFF;
            3:       return 32'sh0;
            default: return $urandom;
        endcase
    endfunction

    // Hold valid low for a random number of cycles
    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Offer one request word and hold it until the block takes it.
    // The hint goes in before valid rises, so the monitor always finds it.
    task automatic offer_word(input req_t w, input bit typed, input rsp_t answer);
        hint_t h;
        h.typed = typed;
        h.rsp   = answer;
        hint_q.push_back(h);
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait for every outstanding answer. Poll on the falling
    // edge so the monitor's rising-edge updates have settled.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (due_q.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Receiver: random stall at the current rate, or a long hold-off when the
    // stimulus bumps hold_req. The countdown lives here, in cycles.
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: predict on every accepted request, then check every accepted
    // response against the oldest expectation. Both in one process so a
    // same-edge request and response can never race.
    always @(posedge clk)
    begin : watch
        hint_t h;
        rsp_t  guess;
        rsp_t  want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                guess = deque_step(req);
                if ((req.func == FUNC_POP_FRONT || req.func == FUNC_POP_REAR)
                    && guess.status == STATUS_OK)
                    n_good_pop++;
                if (hint_q.size() != 0)
                begin
                    h = hint_q.pop_front();
                    due_q.push_back(h.typed ? h.rsp : guess);
                end
                else
                begin
                    due_q.push_back(guess);
                end
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (due_q.size() == 0)
                begin
                    report_mismatch($sformatf("response with nothing pending: status %0d value %h",
                                              rsp.status, rsp.popped_value));
                end
                else
                begin
                    want = due_q.pop_front();
                    n_checked++;
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp.status, want.status));
                    if (rsp.popped_value !== want.popped_value)
                        report_mismatch($sformatf("popped value got %h want %h",
                                                  rsp.popped_value, want.popped_value));
                end
                case (rsp.status)
                    STATUS_FULL:  n_full++;
                    STATUS_EMPTY: n_empty++;
                    default:      ;
                endcase
            end
        end
    end

    // Watchdog: end the run if it has clearly hung
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     CYCLE_LIMIT, due_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : stimulus
        req_t w;
        rsp_t answer;
        int   ph;
        int   k;
        int   run_left;
        int   push_pct;

        // Hold reset, then release it on a rising edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sweep, back to back
        foreach (dir_tab[i])
        begin
            w.func              = dir_tab[i].op;
            w.push_value        = dir_tab[i].word;
            answer.status       = dir_tab[i].st;
            answer.popped_value = dir_tab[i].pop;
            offer_word(w, dir_tab[i].typed, answer);
        end
        wait_drained();

        // Random phases. Runs of push-heavy, pop-heavy and balanced words keep
        // the deque swinging between empty and full, so wraps and refusals
        // keep happening. The first and last phases open with a long receiver
        // hold-off while the sender keeps offering, which backs the block up.
        for (ph = 0; ph < 4; ph++)
        begin
            stall_pct <= RECV_STALL[ph];
            if (ph == 0 || ph == 3)
                hold_req <= hold_req + 1;
            run_left = 0;
            push_pct = 50;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(4, 24);
                    case ($urandom_range(2))
                        0:       push_pct = 85;
                        1:       push_pct = 15;
                        default: push_pct = 50;
                    endcase
                end
                run_left--;
                w.func       = pick_op(push_pct);
                w.push_value = pick_word();
                idle_gap(SENDER_IDLE[ph]);
                offer_word(w, 1'b0, '0);
            end
            // Pause the sender until every answer is back
            wait_drained();
        end

        // Let any stray response show up, then settle the verdict
        repeat (DRAIN_WAIT) @(posedge clk);
        if (due_q.size() != 0)
            report_mismatch($sformatf("%0d answers never arrived", due_q.size()));

        $display("covered: %0d answers checked over directed and four random phases",
                 n_checked);
        $display("covered: %0d refused pushes, %0d refused pops, %0d good pops",
                 n_full, n_empty, n_good_pop);
        if (err_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
